// ----- hw/rtl/hem_pkg.sv -----
// ----------------------------------------------------------------------------
// hem_pkg
// Shared constants, payload types and controller/datapath interface structs
// for the min-heap extract block.
// ----------------------------------------------------------------------------
package hem_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int NUM_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W    = IDX_W + 2;
  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;

  // item commands
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // result register load kinds
  localparam logic [2:0] RESP_NONE    = 3'd0;
  localparam logic [2:0] RESP_LOAD    = 3'd1;
  localparam logic [2:0] RESP_EMPTY   = 3'd2;
  localparam logic [2:0] RESP_FULL    = 3'd3;
  localparam logic [2:0] RESP_EXTRACT = 3'd4;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       push;       // append input value, count up
    logic       rd_root;    // read root, count down, walk index to root
    logic       take_root;  // latch minimum, read last entry
    logic       take_last;  // latch moving entry
    logic       take_left;  // latch left child
    logic       at_right;   // right child data on read port
    logic       rd_left;    // read left child of walk index
    logic       rd_right;   // read right child of walk index
    logic       rd_next;    // read left child of chosen child
    logic       descend;    // move chosen child up, follow it
    logic       wr_v;       // drop moving entry into hole
    logic [2:0] resp;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic left_ok;
    logic right_ok;
    logic go;
    logic next_ok;
  } dp_stat_t;

endpackage

// ----- hw/rtl/hem_ram.sv -----
// ----------------------------------------------------------------------------
// hem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/hem_ctrl.sv -----
// ----------------------------------------------------------------------------
// hem_ctrl
// Sequencer for load and extract items: walks the sift-down one level at a
// time and owns the handshakes.
// ----------------------------------------------------------------------------
module hem_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hem_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  input  hem_pkg::dp_stat_t stat,
  output hem_pkg::dp_cmd_t  cmd
);
  import hem_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROOT  = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_LEFT  = 3'd3;
  localparam logic [2:0] S_RIGHT = 3'd4;
  localparam logic [2:0] S_PLACE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;
  logic       decide;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    decide    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.cmd == CMD_LOAD) begin
            if (stat.full) begin
              cmd.resp = RESP_FULL;
            end else begin
              cmd.push = 1'b1;
              cmd.resp = RESP_LOAD;
            end
          end else begin
            if (stat.empty) begin
              cmd.resp = RESP_EMPTY;
            end else begin
              cmd.rd_root = 1'b1;
              state_nxt   = S_ROOT;
            end
          end
        end
      end
      S_ROOT: begin
        cmd.take_root = 1'b1;
        state_nxt     = S_LAST;
      end
      S_LAST: begin
        cmd.take_last = 1'b1;
        if (stat.left_ok) begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_LEFT;
        end else begin
          cmd.wr_v  = 1'b1;
          cmd.resp  = RESP_EXTRACT;
          state_nxt = S_IDLE;
        end
      end
      S_LEFT: begin
        cmd.take_left = 1'b1;
        if (stat.right_ok) begin
          cmd.rd_right = 1'b1;
          state_nxt    = S_RIGHT;
        end else begin
          decide = 1'b1;
        end
      end
      S_RIGHT: begin
        cmd.at_right = 1'b1;
        decide       = 1'b1;
      end
      S_PLACE: begin
        cmd.wr_v  = 1'b1;
        cmd.resp  = RESP_EXTRACT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (decide) begin
      if (!stat.go) begin
        cmd.wr_v  = 1'b1;
        cmd.resp  = RESP_EXTRACT;
        state_nxt = S_IDLE;
      end else begin
        cmd.descend = 1'b1;
        if (stat.next_ok) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_LEFT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || (cmd.resp != RESP_NONE);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/hem_dpath.sv -----
// ----------------------------------------------------------------------------
// hem_dpath
// Heap storage, entry count, walk index, child compare and result register.
// ----------------------------------------------------------------------------
module hem_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  hem_pkg::in_item_t  in_item,
  input  hem_pkg::dp_cmd_t   cmd,
  output hem_pkg::dp_stat_t  stat,
  output hem_pkg::out_item_t out_item
);
  import hem_pkg::*;

  logic [NUM_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         i_r;
  logic signed [DATA_W-1:0] v_r, lv_r, minv_r;
  logic signed [DATA_W-1:0] rd_data, lval, rval, cand, best_val, wr_data;
  logic [CHILD_W-1:0]       n_w, l_w, r_w, next_l_w;
  logic [IDX_W-1:0]         best_idx, wr_addr, rd_addr;
  logic                     wr_en;
  logic                     sel_l, sel_r;
  out_item_t                res_r, res_nxt;

  // child indexes of the hole
  assign n_w = CHILD_W'(count_r);
  assign l_w = {1'b0, i_r, 1'b1};
  assign r_w = l_w + CHILD_W'(1);

  // smaller child, left wins on a tie, only if strictly below moving entry
  assign lval     = cmd.at_right ? lv_r : rd_data;
  assign rval     = rd_data;
  assign sel_l    = lval < v_r;
  assign cand     = sel_l ? lval : v_r;
  assign sel_r    = cmd.at_right && (rval < cand);
  assign best_idx = sel_r ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
  assign best_val = sel_r ? rval : lval;
  assign next_l_w = {1'b0, best_idx, 1'b1};

  assign stat.full     = (count_r == NUM_W'(HEAP_DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.left_ok  = (l_w < n_w);
  assign stat.right_ok = (r_w < n_w);
  assign stat.go       = sel_l || sel_r;
  assign stat.next_ok  = (next_l_w < n_w);

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + NUM_W'(1);
    end else if (cmd.rd_root) begin
      count_nxt = count_r - NUM_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_r;
    wr_data = v_r;
    if (cmd.push) begin
      wr_en   = 1'b1;
      wr_addr = count_r[IDX_W-1:0];
      wr_data = in_item.value;
    end else if (cmd.descend) begin
      wr_en   = 1'b1;
      wr_data = best_val;
    end else if (cmd.wr_v) begin
      wr_en   = 1'b1;
      wr_data = cmd.take_last ? rd_data : v_r;
    end
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.take_root) begin
      rd_addr = count_r[IDX_W-1:0];
    end else if (cmd.rd_left) begin
      rd_addr = l_w[IDX_W-1:0];
    end else if (cmd.rd_right) begin
      rd_addr = r_w[IDX_W-1:0];
    end else if (cmd.rd_next) begin
      rd_addr = next_l_w[IDX_W-1:0];
    end
  end

  always_comb begin
    res_nxt = res_r;
    case (cmd.resp)
      RESP_NONE:    res_nxt = res_r;
      RESP_LOAD:    res_nxt = '{'0, ST_OK, COUNT_W'(count_nxt)};
      RESP_EMPTY:   res_nxt = '{'0, ST_EMPTY, COUNT_W'(count_nxt)};
      RESP_FULL:    res_nxt = '{'0, ST_FULL, COUNT_W'(count_nxt)};
      RESP_EXTRACT: res_nxt = '{minv_r, ST_OK, COUNT_W'(count_nxt)};
      default:      res_nxt = res_r;
    endcase
  end

  hem_ram #(
    .WIDTH (DATA_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_root) begin
      i_r <= '0;
    end else if (cmd.descend) begin
      i_r <= best_idx;
    end
    if (cmd.take_root) begin
      minv_r <= rd_data;
    end
    if (cmd.take_last) begin
      v_r <= rd_data;
    end
    if (cmd.take_left) begin
      lv_r <= rd_data;
    end
    res_r <= res_nxt;
  end

  assign out_item = res_r;

endmodule

// ----- hw/rtl/heap_extract_min.sv -----
// ----------------------------------------------------------------------------
// heap_extract_min
// Binary min-heap of signed 32-bit words with load and extract-minimum items.
// ----------------------------------------------------------------------------
// The heap lives in a 1024 x 32 RAM with one write and one registered read
// port, and every item yields exactly one result beat. A load beat appends
// its value at the end of the heap (no sift-up: loaded values must already
// form a heap) and its result is ready the next cycle, so loads and rejected
// items are taken one per cycle unless the result beat stalls. An extract
// beat reads the root, moves the last entry into the hole and sifts it down,
// following the smaller child (left on a tie). It latches the root and reads
// the last entry, then at every level reads the left child and, where there
// is one, the right child on the single read port; when the walk ends by
// moving down onto a leaf it places the entry in a step of its own. No new
// beat is taken while it runs. Status is ok, empty (extract with nothing
// stored) or full (load with all entries used); the rejected items leave the
// heap unchanged and return a zero minimum. The RAM needs no clearing after
// reset: only entries below the count are ever read. The result register
// frees the input side as soon as the result beat is being taken.
// ----------------------------------------------------------------------------
module heap_extract_min (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hem_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hem_pkg::out_item_t out_item
);
  import hem_pkg::*;

  dp_cmd_t  cmd;   // sequencer strobes to datapath
  dp_stat_t stat;  // compare and range flags back

  // sequencer: handshakes and sift-down walk
  hem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, count, walk index, child compare, result register
  hem_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// ----- hw/rtl/hem_check.sv -----
// ----------------------------------------------------------------------------
// hem_check
// Port-level checks for the min-heap extract block, bound to the top level.
// ----------------------------------------------------------------------------
module hem_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input hem_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input hem_pkg::out_item_t out_item
);
  import hem_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // a load beat gets its result on the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.cmd == CMD_LOAD) |=> out_valid)
    else $error("load result not ready one cycle after accept");

  // empty reject reports an empty heap and zero minimum
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_EMPTY) |->
      (out_item.count == '0) && (out_item.min_value == '0))
    else $error("empty status with nonzero count or value");

  // full reject reports a full heap and zero minimum
  a_full_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL) |->
      (out_item.count == COUNT_W'(HEAP_DEPTH)) && (out_item.min_value == '0))
    else $error("full status with wrong count or nonzero value");

endmodule

bind heap_extract_min hem_check u_hem_check (.*);

// ----- bench/tb_heap_extract_min.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heap_extract_min
// Self-checking bench for the min-heap extract block. A heap model in the
// bench follows every accepted beat and queues the result it must produce.
// Each result beat is checked field by field against that queue. Stimulus
// covers empty and full heaps, extreme values, equal keys, long sorted runs
// with random content, and random noise. It also holds off the receiver for
// a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_heap_extract_min;
  import hem_pkg::*;

  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;   // longer than one worst-case extract
  localparam int FULL_TAKES   = 30;   // deep walks out of the full heap

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  heap_extract_min i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // heap model state, advanced once per accepted input beat
  logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
  int                       heap_fill = 0;

  // results owed by the block, oldest first
  out_item_t heap_answers [$];
  int        mismatch_cnt = 0;

  // idle and stall rates, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // receiver hold-off: a toggle on hold_req starts one long stall
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  // top of the current ascending run, keeps appended loads a valid heap
  logic signed [DATA_W-1:0] run_top = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one beat to the heap model and return the result it yields
  function automatic out_item_t heap_apply(in_item_t beat);
    out_item_t                res;
    int                       pos;
    int                       lc;
    int                       rc;
    int                       best;
    logic signed [DATA_W-1:0] tmp;
    res = '0;
    if (beat.cmd == CMD_LOAD) begin
      if (heap_fill >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        heap_mem[heap_fill] = beat.value;
        heap_fill++;
      end
    end else if (heap_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.min_value = heap_mem[0];
      heap_fill--;
      heap_mem[0] = heap_mem[heap_fill];
      pos = 0;
      // sift down: strictly smaller child wins, left on a tie
      while (pos < heap_fill) begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        if (lc < heap_fill && heap_mem[lc] < heap_mem[best]) best = lc;
        if (rc < heap_fill && heap_mem[rc] < heap_mem[best]) best = rc;
        if (best == pos) break;
        tmp            = heap_mem[pos];
        heap_mem[pos]  = heap_mem[best];
        heap_mem[best] = tmp;
        pos            = best;
      end
    end
    res.count = COUNT_W'(heap_fill);
    return res;
  endfunction

  // offer one beat, hold it until taken, then log what it must produce
  task automatic send_beat(input logic cmd, input logic signed [DATA_W-1:0] value);
    in_item_t beat;
    beat.cmd   = cmd;
    beat.value = value;
    // random idle cycles ahead of the beat
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    heap_answers.push_back(heap_apply(beat));
  endtask

  // next value of an ascending run: random step, zero now and then for ties
  task automatic bump_run_top;
    logic signed [DATA_W:0] sum;
    int                     step;
    if ($urandom_range(0, 3) == 0) step = 0;
    else step = $urandom_range(0, 1 << $urandom_range(0, 24));
    sum = (DATA_W+1)'(run_top);
    sum = sum + step;
    if (sum > 33'sh0_7FFF_FFFF) run_top = 32'sh7FFF_FFFF;
    else run_top = sum[DATA_W-1:0];
  endtask

  // extract right after reset: nothing stored
  task automatic test_empty_heap;
    send_beat(CMD_EXTRACT, 32'sh0000_0000);
    send_beat(CMD_EXTRACT, 32'shFFFF_FFFF);
  endtask

  // most negative, -1, 0, most positive; then a root larger than its child
  task automatic test_extreme_values;
    send_beat(CMD_LOAD, 32'sh8000_0000);
    send_beat(CMD_LOAD, 32'shFFFF_FFFF);
    send_beat(CMD_LOAD, 32'sh0000_0000);
    send_beat(CMD_LOAD, 32'sh7FFF_FFFF);
    repeat (5) send_beat(CMD_EXTRACT, 32'sh7FFF_FFFF);
    send_beat(CMD_LOAD, 32'sh7FFF_FFFF);
    send_beat(CMD_LOAD, 32'sh8000_0000);
    repeat (2) send_beat(CMD_EXTRACT, 32'sh8000_0000);
  endtask

  // equal children and a moving entry equal to its child
  task automatic test_equal_keys;
    repeat (4) send_beat(CMD_LOAD, 32'sd7);
    send_beat(CMD_LOAD, 32'sd9);
    repeat (5) send_beat(CMD_EXTRACT, 32'sd0);
  endtask

  // mostly ascending runs mixed with extracts, the rest random noise
  task automatic test_random(input int beats);
    repeat (beats) begin
      if (heap_fill == 0) run_top = $signed($urandom) >>> $urandom_range(0, 20);
      if ($urandom_range(0, 99) < 20) begin
        send_beat(1'($urandom_range(0, 1)), $urandom);
      end else if (heap_fill == 0 || $urandom_range(0, 99) < 55) begin
        bump_run_top();
        send_beat(CMD_LOAD, run_top);
      end else begin
        send_beat(CMD_EXTRACT, $urandom);
      end
    end
  endtask

  // receiver holds off while beats keep coming, so the input must stall
  task automatic test_backpressure;
    hold_req <= ~hold_req;
    repeat (20) begin
      bump_run_top();
      send_beat(CMD_LOAD, run_top);
    end
    repeat (20) send_beat(CMD_EXTRACT, $urandom);
  endtask

  // drain, fill every entry, load into the full heap, then deep extracts
  task automatic test_full_heap;
    logic signed [DATA_W-1:0] v;
    while (heap_fill != 0) send_beat(CMD_EXTRACT, $urandom);
    v = 32'sh8000_0000 + $urandom_range(0, 1000);
    while (heap_fill < HEAP_DEPTH) begin
      send_beat(CMD_LOAD, v);
      v = v + $urandom_range(0, 1000);
    end
    repeat (2) send_beat(CMD_LOAD, $urandom);
    repeat (FULL_TAKES) send_beat(CMD_EXTRACT, $urandom);
  endtask

  // result side: check each taken beat, then pick the next stall value
  always @(posedge clk) begin : result_side
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (heap_answers.size() == 0) begin
        $error("result beat with nothing pending: min_value %0d status %0d count %0d",
               out_item.min_value, out_item.status, out_item.count);
        mismatch_cnt++;
      end else begin
        want = heap_answers.pop_front();
        if (out_item.min_value !== want.min_value) begin
          $error("min_value: expected %0d, actual %0d", want.min_value, out_item.min_value);
          mismatch_cnt++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          mismatch_cnt++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_item.count);
          mismatch_cnt++;
        end
      end
    end
    // a new hold request wins over random stalls
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // sender idles a little, receiver a lot
    send_idle_pct  <= 11;
    recv_stall_pct <= 45;
    @(posedge clk);
    test_empty_heap();
    test_extreme_values();
    test_equal_keys();
    test_random(50);
    // the other way round
    send_idle_pct  <= 45;
    recv_stall_pct <= 11;
    test_backpressure();
    test_random(50);
    // back to back on both sides
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    test_full_heap();
    test_random(20);
    in_valid <= 1'b0;
    while (heap_answers.size() != 0) @(posedge clk);
    // catch any stray beat after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && heap_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hem_pkg.sv
hw/rtl/hem_ram.sv
hw/rtl/hem_ctrl.sv
hw/rtl/hem_dpath.sv
hw/rtl/heap_extract_min.sv
hw/rtl/hem_check.sv
bench/tb_heap_extract_min.sv
